@@ design/ils_pkg.sv @@
package ils_pkg;

   localparam int unsigned DEFAULT_CAPACITY   = 16;
   localparam int unsigned DEFAULT_ENTRY_BITS = 32;

   localparam int unsigned OPCODE_BITS = 2;
   localparam int unsigned POS_BITS    = 5;
   localparam int unsigned DATA_BITS   = 32;
   localparam int unsigned STATUS_BITS = 2;
   localparam int unsigned COUNT_BITS  = 5;

   localparam logic [OPCODE_BITS-1:0] OP_PUSH   = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_POP    = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_INSERT = 2'd2;
   localparam logic [OPCODE_BITS-1:0] OP_REMOVE = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctrl_type;

endpackage

@@ design/ils_cell.sv @@
module ils_cell #(
   parameter int unsigned CAPACITY   = 16,
   parameter int unsigned ENTRY_BITS = 32,
   parameter int unsigned INDEX      = 0
) (
   input  logic                         clock,
   input  ils_pkg::cell_ctrl_type       ctrl,
   input  logic [$clog2(CAPACITY)-1:0]  pos,
   input  logic [ENTRY_BITS-1:0]        data,
   input  logic [ENTRY_BITS-1:0]        left_entry,
   input  logic [ENTRY_BITS-1:0]        right_entry,
   output logic [ENTRY_BITS-1:0]        entry,
   output logic [ENTRY_BITS-1:0]        tap
);
   import ils_pkg::*;

   localparam int unsigned IDX_BITS = $clog2(CAPACITY);
   localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(INDEX);

   logic [ENTRY_BITS-1:0] entry_ff;
   logic [ENTRY_BITS-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (MY_IDX > pos) begin
            entry_in = left_entry;
         end else if (MY_IDX == pos) begin
            entry_in = data;
         end
      end else if (ctrl.rem && (MY_IDX >= pos)) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign tap   = (ctrl.rem && (MY_IDX == pos)) ? entry_ff : '0;

endmodule

@@ design/indexed_list_shift_store.sv @@
// Result: a request accepted at one clock edge has its result registered onto the rsp_
// ports, marked by rsp_strobe; the receiver cannot stall.
// Throughput: one request per cycle; busy stays low, since every cell of the row
// shifts or loads its entry in the same cycle that the request is accepted.
// Reset: synchronous and active high; it empties the list and clears the strobe,
// while the entry cells keep whatever they hold.
module indexed_list_shift_store #(
   parameter int unsigned CAPACITY   = ils_pkg::DEFAULT_CAPACITY,
   parameter int unsigned ENTRY_BITS = ils_pkg::DEFAULT_ENTRY_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ils_pkg::OPCODE_BITS-1:0]   req_opcode,
   input  logic [ils_pkg::POS_BITS-1:0]      req_position,
   input  logic [ils_pkg::DATA_BITS-1:0]     req_entry_in,
   output logic                              rsp_strobe,
   output logic [ils_pkg::DATA_BITS-1:0]     rsp_entry_out,
   output logic [ils_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [ils_pkg::COUNT_BITS-1:0]    rsp_count
);
   import ils_pkg::*;

   localparam int unsigned IDX_BITS  = $clog2(CAPACITY);
   localparam int unsigned FILL_BITS = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_BITS  = (FILL_BITS > POS_BITS) ? FILL_BITS : POS_BITS;
   localparam logic [FILL_BITS-1:0] CAP_FILL = FILL_BITS'(CAPACITY);

   logic                    accept;
   logic [FILL_BITS-1:0]    fill_ff;
   logic [FILL_BITS-1:0]    fill_in;
   logic [CMP_BITS-1:0]     pos_ext;
   logic [CMP_BITS-1:0]     fill_ext;
   logic [IDX_BITS-1:0]     cell_pos;
   cell_ctrl_type           ctrl;
   logic [STATUS_BITS-1:0]  status;
   logic [ENTRY_BITS-1:0]   entry_data;
   logic [ENTRY_BITS-1:0]   taken;
   logic [DATA_BITS-1:0]    taken_out;
   logic [COUNT_BITS-1:0]   count_out;
   logic [ENTRY_BITS-1:0]   entries [CAPACITY];
   logic [ENTRY_BITS-1:0]   taps [CAPACITY];

   logic                    rsp_strobe_ff;
   logic [DATA_BITS-1:0]    rsp_entry_out_ff;
   logic [STATUS_BITS-1:0]  rsp_status_ff;
   logic [COUNT_BITS-1:0]   rsp_count_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign pos_ext  = CMP_BITS'(req_position);
   assign fill_ext = CMP_BITS'(fill_ff);

   generate
      if (ENTRY_BITS <= DATA_BITS) begin : g_narrow
         assign entry_data = req_entry_in[ENTRY_BITS-1:0];
         assign taken_out  = DATA_BITS'(taken);
      end else begin : g_wide
         assign entry_data = ENTRY_BITS'(req_entry_in);
         assign taken_out  = taken[DATA_BITS-1:0];
      end
      if (FILL_BITS >= COUNT_BITS) begin : g_count_trunc
         assign count_out = fill_in[COUNT_BITS-1:0];
      end else begin : g_count_ext
         assign count_out = COUNT_BITS'(fill_in);
      end
   endgenerate

   // Push is an insert at the end and pop is a remove of the last entry.
   always_comb begin
      ctrl     = '0;
      status   = ST_OK;
      fill_in  = fill_ff;
      cell_pos = pos_ext[IDX_BITS-1:0];
      case (req_opcode)
         OP_PUSH: begin
            cell_pos = fill_ff[IDX_BITS-1:0];
            if (fill_ff == CAP_FILL) begin
               status = ST_FULL;
            end else begin
               ctrl.ins = accept;
               fill_in  = fill_ff + FILL_BITS'(1);
            end
         end
         OP_POP: begin
            cell_pos = IDX_BITS'(fill_ff - FILL_BITS'(1));
            if (fill_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               ctrl.rem = accept;
               fill_in  = fill_ff - FILL_BITS'(1);
            end
         end
         OP_INSERT: begin
            if (pos_ext > fill_ext) begin
               status = ST_RANGE;
            end else if (fill_ff == CAP_FILL) begin
               status = ST_FULL;
            end else begin
               ctrl.ins = accept;
               fill_in  = fill_ff + FILL_BITS'(1);
            end
         end
         OP_REMOVE: begin
            if (pos_ext >= fill_ext) begin
               status = ST_RANGE;
            end else begin
               ctrl.rem = accept;
               fill_in  = fill_ff - FILL_BITS'(1);
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic [ENTRY_BITS-1:0] left_entry;
         logic [ENTRY_BITS-1:0] right_entry;
         if (i == 0) begin : g_first
            assign left_entry = entry_data;
         end else begin : g_left
            assign left_entry = entries[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_entry = '0;
         end else begin : g_right
            assign right_entry = entries[i+1];
         end
         ils_cell #(
            .CAPACITY   (CAPACITY),
            .ENTRY_BITS (ENTRY_BITS),
            .INDEX      (i)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .pos         (cell_pos),
            .data        (entry_data),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .tap         (taps[i])
         );
      end
   endgenerate

   always_comb begin
      taken = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         taken = taken | taps[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_entry_out_ff <= taken_out;
         rsp_status_ff    <= status;
         rsp_count_ff     <= count_out;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_entry_out = rsp_entry_out_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;

`ifndef SYNTHESIS
   a_one_result_per_transfer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("accepted request produced no result");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("result without an accepted request");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CAP_FILL)
      else $error("fill count beyond capacity");

   a_error_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_OK)) |-> $stable(fill_ff))
      else $error("failed request changed the fill count");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == OP_PUSH) && (fill_ff != CAP_FILL))
      |=> (fill_ff == $past(fill_ff) + FILL_BITS'(1)))
      else $error("push did not grow the list");
`endif

endmodule
